// ===== src/ptr_pkg.sv =====
package ptr_pkg;

    // Default sizes of the tables.
    localparam int NumFramesDef    = 16;
    localparam int PagesPerProcDef = 64;
    localparam int NumProcsDef     = 8;

    // Fixed field widths.
    localparam int ProcW  = 3;
    localparam int VaW    = 22;
    localparam int PaW    = 20;
    localparam int VpageW = 6;
    localparam int FrameW = 4;
    localparam int CntW   = 32;
    localparam int StampW = 64;
    localparam int ShiftW = 5;
    localparam int PolW   = 2;

    // Register indexes.
    localparam logic [0:0] RegPolicy = 1'b0;
    localparam logic [0:0] RegShift  = 1'b1;

    // Policy codes.
    localparam logic [PolW-1:0] PolFifo  = 2'd0;
    localparam logic [PolW-1:0] PolLru   = 2'd1;
    localparam logic [PolW-1:0] PolClock = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input word and look up the page table
        logic check;     // decide range and hit from the table read
        logic hit_upd;   // apply a hit
        logic scan_init; // start the frame scan
        logic scan_step; // examine one frame
        logic vic_rd;    // read the victim page table slot
        logic fill;      // install the new page
        logic oor;       // build an out of range result
        logic emit;      // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic oor;
        logic hit;
        logic scan_done;
        logic out_full;
    } t_sts;

endpackage

// ===== src/page_translate_replace.sv =====
// Demand paging translator with FIFO, LRU or clock replacement.
// Input stream: one word per access, proc_id and virt_addr. Output stream:
// one result word per access. Config channel: index 0 sets the replace
// policy, index 1 the page shift; write only while the block is idle.
// A word is taken only while no access is in flight, so one access is
// processed at a time. A hit or an out of range access passes through the
// lookup, check and emit states. A fault scans the frame table one frame a
// cycle, then reads the victim slot and fills the frame: a free frame ends
// the scan at the lowest free index, a FIFO or LRU eviction scans every
// frame, and a clock eviction then also sweeps the hand. The scan loop over
// the frames sets the fault latency. The input is ready again once the
// result is in the output register. Reset empties every frame, which drops
// all mappings, clears the access clock, the clock hand and both counters,
// and restores the policy to FIFO and the page shift to 12. A stalled
// receiver holds the result in the output register; one more access is
// processed meanwhile and then waits for the register, so the input stalls
// until the result has left.
module page_translate_replace #(
    parameter int FRAME_COUNT    = ptr_pkg::NumFramesDef,
    parameter int PAGES_PER_PROC = ptr_pkg::PagesPerProcDef,
    parameter int NUM_PROCS      = ptr_pkg::NumProcsDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [4:0]   i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,  // proc_id[2:0], virt_addr[24:3]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // phys_addr[19:0], was_hit[20], out_of_range[21], did_evict[22],
    // victim_proc[25:23], victim_page[31:26], frame_used[35:32],
    // hits_so_far[67:36], faults_so_far[99:68]
    output logic [103:0] m_axis_tdata
);
    import ptr_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    ptr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ptr_dp #(
        .FRAME_COUNT    (FRAME_COUNT),
        .PAGES_PER_PROC (PAGES_PER_PROC),
        .NUM_PROCS      (NUM_PROCS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata[ProcW+VaW-1:0]),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// ===== src/ptr_ctrl.sv =====
module ptr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ptr_pkg::t_sts i_sts,
    output ptr_pkg::t_cmd o_cmd
);
    import ptr_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOOK  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_VIC   = 3'd4;
    localparam logic [2:0] S_FILL  = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0] r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Sequence an access: lookup, fault scan and fill, result.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: n_state = S_CHECK;
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_sts.oor) begin
                    o_cmd.oor = 1'b1;
                    n_state   = S_EMIT;
                end else if (i_sts.hit) begin
                    o_cmd.hit_upd = 1'b1;
                    n_state       = S_EMIT;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_done) n_state = S_VIC;
            end
            S_VIC: begin
                o_cmd.vic_rd = 1'b1;
                n_state      = S_FILL;
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (!i_sts.out_full) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

endmodule

// ===== src/ptr_dp.sv =====
module ptr_dp #(
    parameter int FRAME_COUNT    = ptr_pkg::NumFramesDef,
    parameter int PAGES_PER_PROC = ptr_pkg::PagesPerProcDef,
    parameter int NUM_PROCS      = ptr_pkg::NumProcsDef
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    input  logic                      i_cfg_index,
    input  logic [ptr_pkg::ShiftW-1:0] i_cfg_data,
    input  logic [ptr_pkg::ProcW+ptr_pkg::VaW-1:0] i_in_data,
    input  ptr_pkg::t_cmd             i_cmd,
    output ptr_pkg::t_sts             o_sts,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [103:0]              o_out_data
);
    import ptr_pkg::*;

    localparam int FIdxW  = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int PIdxW  = (PAGES_PER_PROC > 1) ? $clog2(PAGES_PER_PROC) : 1;
    localparam int ClrLen = 2 * FRAME_COUNT + 1;
    localparam int CntStW = $clog2(ClrLen + 1);

    // Configuration registers.
    logic [PolW-1:0]   r_policy;
    logic [ShiftW-1:0] r_shift;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= PolFifo;
            r_shift  <= ShiftW'(12);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == RegPolicy) r_policy <= i_cfg_data[PolW-1:0];
            else                          r_shift  <= i_cfg_data;
        end
    end

    // Captured access.
    logic [ProcW-1:0] r_pid;
    logic [VaW-1:0]   r_va;
    logic [VaW-1:0]   w_vpn_full, w_off;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pid <= i_in_data[ProcW-1:0];
            r_va  <= i_in_data[ProcW+VaW-1:ProcW];
        end
    end
    assign w_vpn_full = r_va >> r_shift;
    assign w_off      = r_va & ~({VaW{1'b1}} << r_shift);

    logic w_oor;
    assign w_oor = (w_vpn_full >= VaW'(PAGES_PER_PROC)) || (int'(r_pid) >= NUM_PROCS);

    // Frame table. A page is resident exactly when a busy frame holds it,
    // so the frame table also serves as the page table.
    logic [FRAME_COUNT-1:0] r_busy, r_ref;
    logic [ProcW-1:0]       r_owner [FRAME_COUNT];
    logic [PIdxW-1:0]       r_fpage [FRAME_COUNT];
    logic [StampW-1:0]      r_arr   [FRAME_COUNT];
    logic [StampW-1:0]      r_last  [FRAME_COUNT];

    logic [StampW-1:0] r_clock;
    logic [FIdxW-1:0]  r_hand;
    logic [CntW-1:0]   r_hits, r_faults;

    // Scan state.
    logic [FIdxW-1:0]  r_scan_i, r_best, r_sel;
    logic [StampW-1:0] r_best_st;
    logic [CntStW-1:0] r_steps;
    logic              r_found_free, r_evict, r_done, r_hit;
    logic [FIdxW-1:0]  r_frame;

    // Pending result kind and victim details.
    logic              r_hit_or_oor_oor;
    logic [PIdxW-1:0]  r_fpage_v;
    logic [ProcW-1:0]  r_owner_v;

    // Compare the access against every frame; at most one can match.
    logic [FRAME_COUNT-1:0] w_match;
    logic [FIdxW-1:0]       w_match_fr;
    always_comb begin
        w_match_fr = '0;
        for (int f = FRAME_COUNT - 1; f >= 0; f--) begin
            w_match[f] = r_busy[f] && (r_owner[f] == r_pid)
                         && (r_fpage[f] == w_vpn_full[PIdxW-1:0]);
            if (w_match[f]) w_match_fr = FIdxW'(f);
        end
    end

    // Lookup result, registered.
    logic [FIdxW-1:0] r_match_fr;
    logic             r_match;
    always_ff @(posedge i_clk) begin
        r_match_fr <= w_match_fr;
        r_match    <= |w_match;
    end

    logic [StampW-1:0] w_stamp;
    assign w_stamp = (r_policy == PolLru) ? r_last[r_scan_i] : r_arr[r_scan_i];
    logic [FIdxW-1:0] w_hand_nx;
    assign w_hand_nx = (int'(r_hand) == FRAME_COUNT - 1) ? '0 : r_hand + 1'b1;

    assign o_sts.oor       = w_oor;
    assign o_sts.hit       = r_match;
    assign o_sts.scan_done = r_done;
    assign o_sts.out_full  = o_out_valid && !i_out_ready;

    // Main datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= '0;
            r_clock     <= '0;
            r_hand      <= '0;
            r_hits      <= '0;
            r_faults    <= '0;
            r_done      <= 1'b0;
        end else begin
            if (i_cmd.check && !w_oor) r_clock <= r_clock + 1'b1;
            if (i_cmd.hit_upd) begin
                r_hit   <= 1'b1;
                r_evict <= 1'b0;
                r_frame <= r_match_fr;
                r_last[r_match_fr] <= r_clock + 1'b1;
                r_ref[r_match_fr]  <= 1'b1;
                if (r_hits != '1) r_hits <= r_hits + 1'b1;
            end
            if (i_cmd.scan_init) begin
                r_hit        <= 1'b0;
                r_scan_i     <= '0;
                r_steps      <= '0;
                r_found_free <= 1'b0;
                r_done       <= 1'b0;
                r_best       <= '0;
                r_best_st    <= '1;
                if (r_faults != '1) r_faults <= r_faults + 1'b1;
            end
            // First sweep looks for the lowest free frame and the oldest stamp;
            // clock sweeps follow if needed.
            if (i_cmd.scan_step && !r_done) begin
                if (int'(r_steps) < FRAME_COUNT) begin
                    if (!r_busy[r_scan_i] && !r_found_free) begin
                        r_found_free <= 1'b1;
                        r_sel        <= r_scan_i;
                        r_done       <= 1'b1;
                    end else if (w_stamp < r_best_st || r_steps == '0) begin
                        r_best    <= r_scan_i;
                        r_best_st <= w_stamp;
                    end
                    r_scan_i <= (int'(r_scan_i) == FRAME_COUNT - 1) ? '0 : r_scan_i + 1'b1;
                    r_steps  <= r_steps + 1'b1;
                    if (int'(r_steps) == FRAME_COUNT - 1 && r_busy[r_scan_i]
                        && r_policy != PolClock) begin
                        r_sel  <= (w_stamp < r_best_st) ? r_scan_i : r_best;
                        r_done <= 1'b1;
                    end
                end else begin
                    r_hand <= w_hand_nx;
                    r_steps <= r_steps + 1'b1;
                    if (!r_ref[r_hand] || int'(r_steps) >= ClrLen + FRAME_COUNT - 1) begin
                        r_sel  <= r_hand;
                        r_done <= 1'b1;
                    end else begin
                        r_ref[r_hand] <= 1'b0;
                    end
                end
            end
            if (i_cmd.vic_rd) begin
                r_done    <= 1'b0;
                r_evict   <= !r_found_free;
                r_frame   <= r_sel;
            end
            // Installing the page in its frame also drops the old mapping.
            if (i_cmd.fill) begin
                r_busy[r_frame]    <= 1'b1;
                r_owner[r_frame]   <= r_pid;
                r_fpage[r_frame]   <= w_vpn_full[PIdxW-1:0];
                r_arr[r_frame]     <= r_clock;
                r_last[r_frame]    <= r_clock;
                r_ref[r_frame]     <= 1'b1;
            end
        end
    end

    // Output register.
    logic [PaW-1:0] w_pa;
    logic [63:0]    w_pa_wide;
    assign w_pa_wide = (64'(r_frame) << r_shift) + 64'(w_off);
    assign w_pa      = w_pa_wide[PaW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
            if (r_hit_or_oor_oor) begin
                o_out_data <= {4'd0, r_faults, r_hits, 4'd0, 6'd0, 3'd0, 1'b0,
                               1'b1, 1'b0, 20'd0};
            end else begin
                o_out_data <= {4'd0, r_faults, r_hits, FrameW'(r_frame),
                               r_evict ? VpageW'(r_fpage_v) : 6'd0,
                               r_evict ? r_owner_v : 3'd0,
                               r_evict, 1'b0, r_hit, w_pa};
            end
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    // Remember whether the pending result is out of range, and victim details.
    always_ff @(posedge i_clk) begin
        if (i_cmd.check) r_hit_or_oor_oor <= i_cmd.oor;
        if (i_cmd.vic_rd) begin
            r_fpage_v <= r_fpage[r_sel];
            r_owner_v <= r_owner[r_sel];
        end
    end

endmodule
